// File: rtl/core/mfte_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the monochrome framebuffer text engine.
// No dependencies; the front, back and top level refer to it by scoped names.
package mfte_pkg;

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_SIZE    = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W        = $clog2(STORE_SIZE);

   localparam int MODE_W    = 3;
   localparam int COORD_W   = 8;
   localparam int GLYPH_W   = 16;
   localparam int ROW_W     = 5;
   localparam int FONT_WD_W = 5;
   localparam int FONT_HT_W = 6;
   localparam int BYTE_W    = 8;
   localparam int BIT_SEL_W = 3;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MODE_W-1:0] MODE_CURSOR = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PIXEL  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FILL   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TOGGLE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_GLYPH  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_FONT_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FONT_HEIGHT = 1'b1;

   localparam logic [FONT_WD_W-1:0] FONT_WIDTH_RST  = 5'd7;
   localparam logic [FONT_HT_W-1:0] FONT_HEIGHT_RST = 6'd10;

   localparam logic [BYTE_W-1:0] BYTE_ONES  = 8'hFF;
   localparam logic [BYTE_W-1:0] BYTE_ZEROS = 8'h00;

   // Decoded request as it travels from the front to the back.
   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [COORD_W-1:0]   x_pos;
      logic [COORD_W-1:0]   y_pos;
      logic                 pixel_color;
      logic [GLYPH_W-1:0]   glyph_bits;
      logic [ROW_W-1:0]     glyph_row;
      logic                 last_row;
      logic                 range_bad;
      logic [ADDR_W-1:0]    addr;
      logic [BIT_SEL_W-1:0] bit_sel;
   } cmd_type;

endpackage

// File: rtl/core/mfte_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, decodes range checks and byte addresses,
// and holds them in a short queue for the back end. Uses mfte_pkg.
module mfte_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mfte_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [mfte_pkg::MODE_W-1:0]         req_tuser,
   input  logic                                req_tlast,
   input  logic                                init_busy,
   input  logic                                cmd_pop,
   output logic                                cmd_valid,
   output mfte_pkg::cmd_type                   cmd_out
);

   mfte_pkg::cmd_type                   dec;
   mfte_pkg::cmd_type                   q_mem_ff [mfte_pkg::QUEUE_DEPTH];
   logic [mfte_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [mfte_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [mfte_pkg::QCNT_W-1:0]         cnt_ff, cnt_in;
   logic                                push;
   logic                                pop;

   always_comb begin
      dec             = '0;
      dec.mode        = req_tuser;
      dec.x_pos       = req_tdata[7:0];
      dec.y_pos       = req_tdata[15:8];
      dec.pixel_color = req_tdata[16];
      dec.glyph_bits  = req_tdata[32:17];
      dec.glyph_row   = req_tdata[37:33];
      dec.last_row    = req_tlast;
      if (req_tuser == mfte_pkg::MODE_READ) begin
         // Read addresses a whole page by its number.
         dec.range_bad = (int'(dec.y_pos) >= mfte_pkg::PAGE_COUNT) ||
                         (int'(dec.x_pos) >= mfte_pkg::SCREEN_WIDTH);
         dec.addr      = mfte_pkg::ADDR_W'(int'(dec.y_pos) * mfte_pkg::SCREEN_WIDTH +
                                           int'(dec.x_pos));
      end else begin
         dec.range_bad = (int'(dec.x_pos) >= mfte_pkg::SCREEN_WIDTH) ||
                         (int'(dec.y_pos) >= mfte_pkg::SCREEN_HEIGHT);
         dec.addr      = mfte_pkg::ADDR_W'(int'(dec.y_pos >> 3) * mfte_pkg::SCREEN_WIDTH +
                                           int'(dec.x_pos));
      end
      dec.bit_sel = dec.y_pos[mfte_pkg::BIT_SEL_W-1:0];
   end

   assign req_tready = (int'(cnt_ff) < mfte_pkg::QUEUE_DEPTH) && !init_busy;
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != '0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd_out    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// File: rtl/core/mfte_back.sv
`timescale 1ns / 1ps
// Back end: owns the frame memory, cursor, invert flag and font registers,
// carries out one queued request at a time and drives the response register.
// Uses mfte_pkg.
module mfte_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mfte_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mfte_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                cmd_valid,
   input  mfte_pkg::cmd_type                   head_cmd,
   output logic                                cmd_pop,
   output logic                                init_busy,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mfte_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_PIX_WR  = 3'd2;
   localparam logic [2:0] ST_GLY_CHK = 3'd3;
   localparam logic [2:0] ST_GLY_RD  = 3'd4;
   localparam logic [2:0] ST_GLY_WR  = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   localparam int                 PAD_W    = mfte_pkg::RSP_TDATA_W - mfte_pkg::BYTE_W - 2;
   localparam logic [mfte_pkg::ADDR_W-1:0] LAST_ADDR = mfte_pkg::ADDR_W'(mfte_pkg::STORE_SIZE - 1);

   // The memory holds every byte XORed with the invert flag, so toggling
   // the inversion needs no pass over the image.
   logic [mfte_pkg::BYTE_W-1:0]      mem [mfte_pkg::STORE_SIZE];
   logic [mfte_pkg::BYTE_W-1:0]      rd_ff;
   logic                             mem_we, mem_re;
   logic [mfte_pkg::ADDR_W-1:0]      mem_waddr, mem_raddr;
   logic [mfte_pkg::BYTE_W-1:0]      mem_wdata;

   logic [2:0]                       state_ff, state_in;
   mfte_pkg::cmd_type                cmd_ff, cmd_in;
   logic [mfte_pkg::ADDR_W-1:0]      sweep_ff, sweep_in;
   logic [mfte_pkg::BYTE_W-1:0]      fill_ff, fill_in;
   logic                             sweep_rsp_ff, sweep_rsp_in;
   logic                             inv_ff, inv_in;
   logic [mfte_pkg::COORD_W-1:0]     cur_x_ff, cur_x_in;
   logic [mfte_pkg::COORD_W-1:0]     cur_y_ff, cur_y_in;
   logic [mfte_pkg::FONT_WD_W-1:0]   fw_ff, fw_in;
   logic [mfte_pkg::FONT_HT_W-1:0]   fh_ff, fh_in;
   logic [mfte_pkg::FONT_WD_W-1:0]   col_ff, col_in;
   logic                             status_ff, status_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [mfte_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [mfte_pkg::COORD_W:0]       gy;
   logic [mfte_pkg::COORD_W-1:0]     gx;
   logic                             gy_on;
   logic                             fit_bad;
   logic [mfte_pkg::ADDR_W-1:0]      gaddr;
   logic [mfte_pkg::BYTE_W-1:0]      gmask;
   logic [3:0]                       gbit_idx;
   logic                             gon;
   logic                             gcolor;
   logic [mfte_pkg::BYTE_W-1:0]      pmask;
   logic [mfte_pkg::BYTE_W-1:0]      rsp_byte;
   logic                             rsp_free;

   assign init_busy  = (state_ff == ST_CLEAR) && !sweep_rsp_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Glyph column geometry for the column under work.
   always_comb begin
      gy       = {1'b0, cur_y_ff} + (mfte_pkg::COORD_W + 1)'(cmd_ff.glyph_row);
      gx       = cur_x_ff + mfte_pkg::COORD_W'(col_ff);
      gy_on    = int'(gy) < mfte_pkg::SCREEN_HEIGHT;
      fit_bad  = (int'(cur_x_ff) + int'(fw_ff) >= mfte_pkg::SCREEN_WIDTH) ||
                 (int'(cur_y_ff) + int'(fh_ff) >= mfte_pkg::SCREEN_HEIGHT);
      gaddr    = mfte_pkg::ADDR_W'(int'(gy >> 3) * mfte_pkg::SCREEN_WIDTH + int'(gx));
      gmask    = mfte_pkg::BYTE_W'(1) << gy[mfte_pkg::BIT_SEL_W-1:0];
      gbit_idx = 4'(mfte_pkg::GLYPH_W - 1) - col_ff[3:0];
      gon      = !col_ff[4] && cmd_ff.glyph_bits[gbit_idx];
      gcolor   = gon ? cmd_ff.pixel_color : !cmd_ff.pixel_color;
      pmask    = mfte_pkg::BYTE_W'(1) << cmd_ff.bit_sel;
      rsp_byte = ((cmd_ff.mode == mfte_pkg::MODE_READ) && !status_ff) ?
                 (rd_ff ^ {mfte_pkg::BYTE_W{inv_ff}}) : mfte_pkg::BYTE_ZEROS;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      sweep_in     = sweep_ff;
      fill_in      = fill_ff;
      sweep_rsp_in = sweep_rsp_ff;
      inv_in       = inv_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      col_in       = col_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = sweep_ff;
      mem_wdata    = fill_ff;
      mem_re       = 1'b0;
      mem_raddr    = head_cmd.addr;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               status_in = 1'b0;
               state_in  = sweep_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop   = 1'b1;
               cmd_in    = head_cmd;
               status_in = 1'b0;
               state_in  = ST_DONE;
               unique case (head_cmd.mode)
                  mfte_pkg::MODE_CURSOR: begin
                     cur_x_in = head_cmd.x_pos;
                     cur_y_in = head_cmd.y_pos;
                  end
                  mfte_pkg::MODE_PIXEL: begin
                     if (head_cmd.range_bad) begin
                        status_in = 1'b1;
                     end else begin
                        mem_re   = 1'b1;
                        state_in = ST_PIX_WR;
                     end
                  end
                  mfte_pkg::MODE_FILL: begin
                     fill_in      = (head_cmd.pixel_color ? mfte_pkg::BYTE_ONES :
                                     mfte_pkg::BYTE_ZEROS) ^ {mfte_pkg::BYTE_W{inv_ff}};
                     sweep_in     = '0;
                     sweep_rsp_in = 1'b1;
                     state_in     = ST_CLEAR;
                  end
                  mfte_pkg::MODE_TOGGLE: begin
                     inv_in = !inv_ff;
                  end
                  mfte_pkg::MODE_GLYPH: begin
                     state_in = ST_GLY_CHK;
                  end
                  mfte_pkg::MODE_READ: begin
                     if (head_cmd.range_bad) begin
                        status_in = 1'b1;
                     end else begin
                        mem_re = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PIX_WR: begin
            // The stored bit is the requested colour as given, so while inverted the pixel reads back inverted.
            mem_we    = 1'b1;
            mem_waddr = cmd_ff.addr;
            mem_wdata = cmd_ff.pixel_color ? (rd_ff | pmask) : (rd_ff & ~pmask);
            state_in  = ST_DONE;
         end
         ST_GLY_CHK: begin
            col_in   = '0;
            state_in = ST_DONE;
            if (fit_bad) begin
               status_in = 1'b1;
            end else if (gy_on && (fw_ff != '0)) begin
               state_in = ST_GLY_RD;
            end else if (cmd_ff.last_row) begin
               cur_x_in = cur_x_ff + mfte_pkg::COORD_W'(fw_ff);
            end
         end
         ST_GLY_RD: begin
            mem_re    = 1'b1;
            mem_raddr = gaddr;
            state_in  = ST_GLY_WR;
         end
         ST_GLY_WR: begin
            mem_we    = 1'b1;
            mem_waddr = gaddr;
            mem_wdata = gcolor ? (rd_ff | gmask) : (rd_ff & ~gmask);
            if (col_ff == fw_ff - 1'b1) begin
               state_in = ST_DONE;
               if (cmd_ff.last_row) begin
                  cur_x_in = cur_x_ff + mfte_pkg::COORD_W'(fw_ff);
               end
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = ST_GLY_RD;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {PAD_W'(0), inv_ff, rsp_byte, status_ff};
               sweep_rsp_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      fw_in = fw_ff;
      fh_in = fh_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mfte_pkg::CSR_FONT_WIDTH:  fw_in = csr_wdata[mfte_pkg::FONT_WD_W-1:0];
            mfte_pkg::CSR_FONT_HEIGHT: fh_in = csr_wdata[mfte_pkg::FONT_HT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         fill_ff      <= mfte_pkg::BYTE_ZEROS;
         sweep_rsp_ff <= 1'b0;
         inv_ff       <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         fw_ff        <= mfte_pkg::FONT_WIDTH_RST;
         fh_ff        <= mfte_pkg::FONT_HEIGHT_RST;
         col_ff       <= '0;
         status_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         fill_ff      <= fill_in;
         sweep_rsp_ff <= sweep_rsp_in;
         inv_ff       <= inv_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         fw_ff        <= fw_in;
         fh_ff        <= fh_in;
         col_ff       <= col_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_raddr];
      end
   end

endmodule

// File: rtl/core/mono_framebuffer_text_engine_top.sv
`timescale 1ns / 1ps
// Top level of the monochrome framebuffer text engine: a decoding front end
// and queue (mfte_front) feeding the executing back end (mfte_back). Uses mfte_pkg.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         tvalid/tready        tuser mode, tdata fields, tlast last row
//   rsp_      out        tvalid/tready        tdata status, read data, invert flag
//   csr_      in         wr_en (no wait)      index, write data
//
// The back end runs one request at a time from a two-entry queue. Cursor set, invert
// toggle, byte read, unused modes and a rejected pixel go straight to the response; a
// pixel reads, modifies and writes one byte of the frame memory; a glyph row checks
// the fit, then reads and writes one byte per font column (none when it is rejected,
// its row is off screen or the width is zero); a fill writes every byte. After reset
// a clearing pass zeroes the frame memory and holds req_tready low. A stalled response
// waits in its register while the queue keeps taking requests until it is full.
module mono_framebuffer_text_engine_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // x_pos[7:0], y_pos[15:8], pixel_color[16], glyph_bits[32:17], glyph_row[37:33]
   input  logic [mfte_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // mode[2:0]
   input  logic [mfte_pkg::MODE_W-1:0]         req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status[0], read_data[8:1], inverted_now[9]
   output logic [mfte_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [mfte_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mfte_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   mfte_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              cmd_pop;
   logic              init_busy;

   mfte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .init_busy  (init_busy),
      .cmd_pop    (cmd_pop),
      .cmd_valid  (cmd_valid),
      .cmd_out    (cmd)
   );

   mfte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (cmd_valid),
      .head_cmd   (cmd),
      .cmd_pop    (cmd_pop),
      .init_busy  (init_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the monochrome framebuffer text engine top level.
// Depends on mfte_pkg and the RTL only; it predicts every response from a shadow model.
module testbench;
   import mfte_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [COORD_W-1:0] x_pos;
      logic [COORD_W-1:0] y_pos;
      logic               pixel_color;
      logic [GLYPH_W-1:0] glyph_bits;
      logic [ROW_W-1:0]   glyph_row;
      logic               last_row;
   } fb_req_type;

   typedef struct packed {
      logic              status;
      logic [BYTE_W-1:0] read_data;
      logic              inverted_now;
   } fb_rsp_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]      req_tuser  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Shadow copy of the block's state, updated as requests are accepted.
   logic [BYTE_W-1:0]    shadow_fb [STORE_SIZE];
   logic                 shadow_inv;
   logic [COORD_W-1:0]   shadow_cur_x;
   logic [COORD_W-1:0]   shadow_cur_y;
   logic [FONT_WD_W-1:0] shadow_font_wd;
   logic [FONT_HT_W-1:0] shadow_font_ht;

   fb_rsp_type frame_rsp_due[$];
   int      err_count     = 0;
   int      rsp_hold_left = 0;
   int      n_sent        = 0;
   bit      gaps_on       = 1'b1;
   bit      stalls_on     = 1'b1;

   mono_framebuffer_text_engine_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic put_shadow_pixel(input int px, input int py, input logic c);
      int addr;
      if (px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT) return 1'b1;
      if (shadow_inv) c = ~c;
      addr = px + (py / 8) * SCREEN_WIDTH;
      shadow_fb[addr][py % 8] = c;
      return 1'b0;
   endfunction

   function automatic fb_rsp_type predict_frame_op(input fb_req_type r);
      fb_rsp_type res;
      logic    pix_on;
      res = '0;
      unique case (r.mode)
         MODE_CURSOR: begin
            shadow_cur_x = r.x_pos;
            shadow_cur_y = r.y_pos;
         end
         MODE_PIXEL: begin
            res.status = put_shadow_pixel(int'(r.x_pos), int'(r.y_pos), r.pixel_color);
         end
         MODE_FILL: begin
            foreach (shadow_fb[k]) shadow_fb[k] = r.pixel_color ? BYTE_ONES : BYTE_ZEROS;
         end
         MODE_TOGGLE: begin
            shadow_inv = ~shadow_inv;
            foreach (shadow_fb[k]) shadow_fb[k] = ~shadow_fb[k];
         end
         MODE_GLYPH: begin
            if (int'(shadow_cur_x) + int'(shadow_font_wd) >= SCREEN_WIDTH ||
                int'(shadow_cur_y) + int'(shadow_font_ht) >= SCREEN_HEIGHT) begin
               res.status = 1'b1;
            end else begin
               // Columns past the sixteenth have no font bit and draw the background.
               for (int j = 0; j < int'(shadow_font_wd); j++) begin
                  pix_on = (j < GLYPH_W) ? r.glyph_bits[GLYPH_W-1-j] : 1'b0;
                  void'(put_shadow_pixel(int'(shadow_cur_x) + j,
                                         int'(shadow_cur_y) + int'(r.glyph_row),
                                         pix_on ? r.pixel_color : ~r.pixel_color));
               end
               if (r.last_row) shadow_cur_x = shadow_cur_x + COORD_W'(shadow_font_wd);
            end
         end
         MODE_READ: begin
            if (int'(r.y_pos) >= PAGE_COUNT || int'(r.x_pos) >= SCREEN_WIDTH) begin
               res.status = 1'b1;
            end else begin
               res.read_data = shadow_fb[int'(r.x_pos) + int'(r.y_pos) * SCREEN_WIDTH];
            end
         end
         default: ;
      endcase
      res.inverted_now = shadow_inv;
      return res;
   endfunction

   task automatic note_error(input string msg);
      err_count++;
      if (err_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin : scoreboard
      fb_rsp_type got;
      fb_rsp_type want;
      fb_req_type req;
      if (reset) begin
         foreach (shadow_fb[k]) shadow_fb[k] = BYTE_ZEROS;
         shadow_inv     = 1'b0;
         shadow_cur_x   = '0;
         shadow_cur_y   = '0;
         shadow_font_wd = FONT_WIDTH_RST;
         shadow_font_ht = FONT_HEIGHT_RST;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_FONT_WIDTH) shadow_font_wd = csr_wdata[FONT_WD_W-1:0];
            else shadow_font_ht = csr_wdata[FONT_HT_W-1:0];
         end
         // Check the response before predicting, so a same-edge request cannot mask it.
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0], rsp_tdata[8:1], rsp_tdata[9]};
            if (frame_rsp_due.size() == 0) begin
               note_error($sformatf("response with none expected: tdata=%h", rsp_tdata));
            end else begin
               want = frame_rsp_due.pop_front();
               if (got.status != want.status || got.read_data != want.read_data ||
                   got.inverted_now != want.inverted_now) begin
                  note_error($sformatf(
                     "status exp %0b got %0b, read_data exp %h got %h, inverted exp %0b got %0b",
                     want.status, got.status, want.read_data, got.read_data,
                     want.inverted_now, got.inverted_now));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req = {req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[16],
                   req_tdata[32:17], req_tdata[37:33], req_tlast};
            frame_rsp_due.push_back(predict_frame_op(req));
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : rsp_pacing
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = int'($urandom_range(1, 6)) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Called and returns just after a falling edge; tvalid stays high on return and drops only for a random gap.
   task automatic send_req(input logic [MODE_W-1:0] mode, input logic [7:0] x,
                           input logic [7:0] y, input logic color,
                           input logic [GLYPH_W-1:0] bits, input logic [ROW_W-1:0] row,
                           input logic last);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {2'b00, row, bits, color, y, x};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      n_sent++;
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (frame_rsp_due.size() != 0);
   endtask

   task automatic set_font(input logic [FONT_WD_W-1:0] wd, input logic [FONT_HT_W-1:0] ht);
      wait_drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_FONT_WIDTH;
      csr_wdata <= CSR_DATA_W'(wd);
      @(negedge clock);
      csr_index <= CSR_FONT_HEIGHT;
      csr_wdata <= ht;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Places the cursor where a glyph fits, then draws a few characters of text.
   // Now and then a character is cut short and never gets its last row.
   task automatic send_word();
      int   rows;
      int   cut;
      logic color;
      rows = (shadow_font_ht > 32) ? 32 : ((shadow_font_ht == 0) ? 1 : int'(shadow_font_ht));
      send_req(MODE_CURSOR,
               8'($urandom_range(0, SCREEN_WIDTH - 1 - int'(shadow_font_wd))),
               8'($urandom_range(0, SCREEN_HEIGHT - 1 - int'(shadow_font_ht))),
               1'($urandom), GLYPH_W'($urandom), ROW_W'($urandom), 1'($urandom));
      repeat ($urandom_range(1, 4)) begin
         color = 1'($urandom);
         cut = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, rows)) : rows;
         for (int r = 0; r < cut; r++) begin
            send_req(MODE_GLYPH, 8'($urandom), 8'($urandom), color, GLYPH_W'($urandom),
                     ROW_W'(r), r == rows - 1);
         end
      end
   endtask

   task automatic send_noise();
      int          pick;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [15:0] bits;
      pick = int'($urandom_range(0, 99));
      x    = 8'($urandom);
      y    = 8'($urandom);
      bits = 16'($urandom);
      if (pick < 30) begin
         if ($urandom_range(0, 3) != 0) begin
            x = 8'($urandom_range(0, SCREEN_WIDTH - 1));
            y = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
         end
         send_req(MODE_PIXEL, x, y, 1'($urandom), bits, ROW_W'($urandom), 1'($urandom));
      end else if (pick < 55) begin
         if ($urandom_range(0, 3) != 0) begin
            x = 8'($urandom_range(0, SCREEN_WIDTH - 1));
            y = 8'($urandom_range(0, PAGE_COUNT - 1));
         end
         send_req(MODE_READ, x, y, 1'($urandom), bits, ROW_W'($urandom), 1'($urandom));
      end else if (pick < 58) begin
         send_req(MODE_FILL, x, y, 1'($urandom), bits, ROW_W'($urandom), 1'($urandom));
      end else if (pick < 66) begin
         send_req(MODE_TOGGLE, x, y, 1'($urandom), bits, ROW_W'($urandom), 1'($urandom));
      end else if (pick < 76) begin
         send_req(MODE_CURSOR, x, y, 1'($urandom), bits, ROW_W'($urandom), 1'($urandom));
      end else if (pick < 90) begin
         send_req(MODE_GLYPH, x, y, 1'($urandom), bits, ROW_W'($urandom), 1'($urandom));
      end else begin
         send_req($urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI,
                  x, y, 1'($urandom), bits, ROW_W'($urandom), 1'($urandom));
      end
   endtask

   task automatic test_directed_ops();
      // Reads of a cleared frame, in range and out of range.
      send_req(MODE_READ, 8'd0, 8'd0, 1'b0, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_READ, 8'd127, 8'd7, 1'b1, 16'hFFFF, 5'd31, 1'b1);
      send_req(MODE_READ, 8'd128, 8'd0, 1'b0, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_READ, 8'd0, 8'd8, 1'b0, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_READ, 8'd255, 8'd255, 1'b0, 16'h0000, 5'd0, 1'b0);
      // Corner pixels, then pixels just off each edge.
      send_req(MODE_PIXEL, 8'd0, 8'd0, 1'b1, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_PIXEL, 8'd127, 8'd63, 1'b1, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_PIXEL, 8'd128, 8'd0, 1'b1, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_PIXEL, 8'd0, 8'd64, 1'b1, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_PIXEL, 8'd255, 8'd255, 1'b0, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_READ, 8'd0, 8'd0, 1'b0, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_READ, 8'd127, 8'd7, 1'b0, 16'h0000, 5'd0, 1'b0);
      // While inverted a white pixel lands as black, and fill ignores the flag.
      send_req(MODE_TOGGLE, 8'd0, 8'd0, 1'b0, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_PIXEL, 8'd5, 8'd9, 1'b1, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_READ, 8'd5, 8'd1, 1'b0, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_FILL, 8'd0, 8'd0, 1'b1, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_TOGGLE, 8'd0, 8'd0, 1'b0, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_FILL, 8'd0, 8'd0, 1'b0, 16'h0000, 5'd0, 1'b0);
      // A glyph that just fits in the corner, then one that no longer fits.
      send_req(MODE_CURSOR, 8'd120, 8'd53, 1'b0, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_GLYPH, 8'd0, 8'd0, 1'b1, 16'hFFFF, 5'd0, 1'b0);
      send_req(MODE_GLYPH, 8'd0, 8'd0, 1'b0, 16'h8000, 5'd9, 1'b1);
      send_req(MODE_GLYPH, 8'd0, 8'd0, 1'b1, 16'hA5A5, 5'd0, 1'b1);
      send_req(MODE_CURSOR, 8'd0, 8'd54, 1'b0, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_GLYPH, 8'd0, 8'd0, 1'b1, 16'hFFFF, 5'd0, 1'b0);
      // A row below the glyph falls off the screen without a rejection.
      send_req(MODE_CURSOR, 8'd0, 8'd40, 1'b0, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_GLYPH, 8'd0, 8'd0, 1'b1, 16'hFFFF, 5'd31, 1'b0);
      send_req(MODE_READ, 8'd120, 8'd6, 1'b0, 16'h0000, 5'd0, 1'b0);
      send_req(MODE_SPARE_LO, 8'd3, 8'd3, 1'b1, 16'hFFFF, 5'd31, 1'b1);
      send_req(MODE_SPARE_HI, 8'd255, 8'd255, 1'b1, 16'hFFFF, 5'd31, 1'b1);
   endtask

   task automatic test_font_sweep();
      logic [FONT_WD_W-1:0] wd_set [6] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd5, 5'd7};
      logic [FONT_HT_W-1:0] ht_set [6] = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd40, 6'd10};
      for (int i = 0; i < 6; i++) begin
         set_font(wd_set[i], ht_set[i]);
         send_word();
         repeat (3) begin
            send_req(MODE_READ, 8'($urandom_range(0, SCREEN_WIDTH - 1)),
                     8'($urandom_range(0, PAGE_COUNT - 1)), 1'($urandom),
                     GLYPH_W'($urandom), ROW_W'($urandom), 1'($urandom));
         end
      end
   endtask

   task automatic test_random_traffic();
      int start;
      for (int batch = 0; batch < 8; batch++) begin
         if ($urandom_range(0, 9) == 0) begin
            set_font(FONT_WD_W'($urandom_range(0, 31)), FONT_HT_W'($urandom_range(0, 63)));
         end else begin
            set_font(FONT_WD_W'($urandom_range(1, 16)), FONT_HT_W'($urandom_range(1, 16)));
         end
         start = n_sent;
         while (n_sent - start < 35) begin
            if ($urandom_range(0, 99) < 55) send_word();
            else send_noise();
         end
      end
   endtask

   // The receiver holds off long enough for the queue to fill and stall requests;
   // afterwards the sender waits for every response before going on.
   task automatic test_backpressure();
      rsp_hold_left = 400;
      repeat (30) send_noise();
      wait_drain();
      repeat (10) send_noise();
   endtask

   task automatic test_no_idle_tail();
      int start;
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      start     = n_sent;
      while (n_sent - start < 100) begin
         if ($urandom_range(0, 1) == 0) send_word();
         else send_noise();
      end
   endtask

   initial begin : main_seq
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_font_sweep();
      test_random_traffic();
      test_backpressure();
      test_no_idle_tail();
      wait_drain();
      repeat (20) @(posedge clock);
      if (err_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/mfte_pkg.sv
rtl/core/mfte_front.sv
rtl/core/mfte_back.sv
rtl/core/mono_framebuffer_text_engine_top.sv
tb/testbench.sv
